// ===== rtl/core/ssec_pkg.sv =====
// Shared types and constants of the segment/sphere eye clamp pipeline.
// Used by ssec_mul, ssec_root and segment_sphere_eye_clamp; depends on nothing.
`default_nettype none

package ssec_pkg;

  localparam int CW  = 40;   // coordinate width, Q24.16
  localparam int DW  = 41;   // eye minus target
  localparam int RW  = 39;   // clearance radius
  localparam int MW  = 42;   // multiplier operand width
  localparam int PW  = 84;   // product and dot product width
  localparam int KW  = 32;   // fraction bits of the crossing parameter
  localparam int SW  = 152;  // running value of the quadratic, scaled by 2^64
  localparam int UW  = 116;  // running |d|^2 * k

  localparam logic [1:0] CASE_KEEP   = 2'd0;
  localparam logic [1:0] CASE_PULL   = 2'd1;
  localparam logic [1:0] CASE_INSIDE = 2'd2;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] delta_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    delta_t x;
    delta_t y;
    delta_t z;
  } dvec_t;

  typedef struct packed {
    vec_t       tg;
    vec_t       ey;
    dvec_t      d;
    logic [1:0] kind;
    logic       pick_tg;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/core/segment_sphere_eye_clamp.sv =====
// Top level of the eye clamp: input stage, dot products, case decision, root search, output.
// Depends on ssec_pkg, ssec_mul and ssec_root.
`default_nettype none

// The block takes one target/eye transaction per clock and returns one result per
// transaction, in order. It is a single pipeline that moves as a whole: it advances
// whenever the output register is empty or being taken, so s_axis_tready drops only
// while a finished result waits on m_axis_tready. Most of the pipeline is the root
// search, which resolves one of the 32 fraction bits of the crossing parameter per
// stage; the squared lengths and dot products take two multiplier stages and the
// final scaling of eye minus target takes two more. The clearance radius may be
// written only while no transaction is in flight.
module segment_sphere_eye_clamp (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [38:0]  cfg_wdata,      // clearance radius
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // target_x, target_y, target_z, eye_x, eye_y, eye_z (40 bits each)
  input  wire logic [239:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [119:0]      m_axis_tdata,   // out_x, out_y, out_z (40 bits each)
  output logic [1:0]        m_axis_tuser    // clamp_case
);

  localparam int CW   = ssec_pkg::CW;
  localparam int DW   = ssec_pkg::DW;
  localparam int RW   = ssec_pkg::RW;
  localparam int MW   = ssec_pkg::MW;
  localparam int PW   = ssec_pkg::PW;
  localparam int KW   = ssec_pkg::KW;
  localparam int HW   = KW / 2;
  localparam int PHW  = DW + HW + 1;
  localparam int SUMW = DW + KW + 1;
  localparam int NMUL = 13;

  logic en;
  logic [RW-1:0] clear_radius;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_radius <= '0;
    end else if (cfg_we) begin
      clear_radius <= cfg_wdata;
    end
  end

  function automatic logic signed [MW-1:0] ext_c(ssec_pkg::coord_t c);
    return {{(MW-CW){c[CW-1]}}, c};
  endfunction

  function automatic logic signed [MW-1:0] ext_d(ssec_pkg::delta_t c);
    return {{(MW-DW){c[DW-1]}}, c};
  endfunction

  // Input stage.
  ssec_pkg::item_t in_item;
  ssec_pkg::item_t it0, it1, it2, it3, it4;
  logic v0, v1, v2, v3, v4;

  always_comb begin
    in_item         = '0;
    in_item.tg.x    = s_axis_tdata[39:0];
    in_item.tg.y    = s_axis_tdata[79:40];
    in_item.tg.z    = s_axis_tdata[119:80];
    in_item.ey.x    = s_axis_tdata[159:120];
    in_item.ey.y    = s_axis_tdata[199:160];
    in_item.ey.z    = s_axis_tdata[239:200];
    in_item.d.x     = DW'(in_item.ey.x) - DW'(in_item.tg.x);
    in_item.d.y     = DW'(in_item.ey.y) - DW'(in_item.tg.y);
    in_item.d.z     = DW'(in_item.ey.z) - DW'(in_item.tg.z);
    in_item.kind    = ssec_pkg::CASE_KEEP;
    in_item.pick_tg = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v0 <= s_axis_tvalid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it0 <= in_item;
      it1 <= it0;
      it2 <= it1;
      it3 <= it2;
    end
  end

  // Products: |d|^2 terms, |target|^2 terms, |eye|^2 terms, target.d terms, radius^2.
  logic signed [MW-1:0] ma [NMUL];
  logic signed [MW-1:0] mb [NMUL];
  logic signed [PW-1:0] mp [NMUL];

  assign ma[0]  = ext_d(it0.d.x);  assign mb[0]  = ext_d(it0.d.x);
  assign ma[1]  = ext_d(it0.d.y);  assign mb[1]  = ext_d(it0.d.y);
  assign ma[2]  = ext_d(it0.d.z);  assign mb[2]  = ext_d(it0.d.z);
  assign ma[3]  = ext_c(it0.tg.x); assign mb[3]  = ext_c(it0.tg.x);
  assign ma[4]  = ext_c(it0.tg.y); assign mb[4]  = ext_c(it0.tg.y);
  assign ma[5]  = ext_c(it0.tg.z); assign mb[5]  = ext_c(it0.tg.z);
  assign ma[6]  = ext_c(it0.ey.x); assign mb[6]  = ext_c(it0.ey.x);
  assign ma[7]  = ext_c(it0.ey.y); assign mb[7]  = ext_c(it0.ey.y);
  assign ma[8]  = ext_c(it0.ey.z); assign mb[8]  = ext_c(it0.ey.z);
  assign ma[9]  = ext_c(it0.tg.x); assign mb[9]  = ext_d(it0.d.x);
  assign ma[10] = ext_c(it0.tg.y); assign mb[10] = ext_d(it0.d.y);
  assign ma[11] = ext_c(it0.tg.z); assign mb[11] = ext_d(it0.d.z);
  assign ma[12] = {{(MW-RW){1'b0}}, clear_radius};
  assign mb[12] = {{(MW-RW){1'b0}}, clear_radius};

  for (genvar i = 0; i < NMUL; i++) begin : g_mul
    ssec_mul u_mul (
      .clk (clk),
      .en  (en),
      .a   (ma[i]),
      .b   (mb[i]),
      .p   (mp[i])
    );
  end

  // Dot product sums.
  logic signed [PW-1:0] dd3, f0_3, f1_3, ad3;

  always_ff @(posedge clk) begin
    if (en) begin
      dd3  <= mp[0] + mp[1] + mp[2];
      f0_3 <= mp[3] + mp[4] + mp[5] - mp[12];
      f1_3 <= mp[6] + mp[7] + mp[8] - mp[12];
      ad3  <= mp[9] + mp[10] + mp[11];
    end
  end

  // Case decision.
  logic signed [PW-1:0] dd4, f0_4, ad4;
  logic signed [PW:0]   f_diff;
  ssec_pkg::item_t      it_dec;

  assign f_diff = {f0_3[PW-1], f0_3} - {f1_3[PW-1], f1_3};

  always_comb begin
    it_dec = it3;
    if (dd3 == '0 || !f1_3[PW-1]) begin
      it_dec.kind = ssec_pkg::CASE_KEEP;
    end else if (f0_3[PW-1]) begin
      it_dec.kind    = ssec_pkg::CASE_INSIDE;
      it_dec.pick_tg = !f_diff[PW];
    end else begin
      it_dec.kind = ssec_pkg::CASE_PULL;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd4  <= dd3;
      f0_4 <= f0_3;
      ad4  <= ad3;
      it4  <= it_dec;
    end
  end

  // Root search.
  logic            vk;
  logic [KW-1:0]   kk;
  ssec_pkg::item_t itk;

  ssec_root u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .in_dd     (dd4),
    .in_ad     (ad4),
    .in_f0     (f0_4),
    .in_item   (it4),
    .out_valid (vk),
    .out_k     (kk),
    .out_item  (itk)
  );

  // Scale d by k in two halves.
  logic                  v5;
  ssec_pkg::item_t       it5;
  logic signed [PHW-1:0] ph [3];
  logic signed [PHW-1:0] pl [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= vk;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it5   <= itk;
      ph[0] <= itk.d.x * $signed({1'b0, kk[KW-1:HW]});
      ph[1] <= itk.d.y * $signed({1'b0, kk[KW-1:HW]});
      ph[2] <= itk.d.z * $signed({1'b0, kk[KW-1:HW]});
      pl[0] <= itk.d.x * $signed({1'b0, kk[HW-1:0]});
      pl[1] <= itk.d.y * $signed({1'b0, kk[HW-1:0]});
      pl[2] <= itk.d.z * $signed({1'b0, kk[HW-1:0]});
    end
  end

  // Output stage: target + floor(d*k / 2^32), or an endpoint.
  logic signed [SUMW-1:0] prod [3];
  ssec_pkg::coord_t       pulled [3];
  ssec_pkg::vec_t         res;

  for (genvar i = 0; i < 3; i++) begin : g_scale
    assign prod[i] = (SUMW'(ph[i]) <<< HW) + SUMW'(pl[i]);
  end

  assign pulled[0] = it5.tg.x + prod[0][KW+CW-1:KW];
  assign pulled[1] = it5.tg.y + prod[1][KW+CW-1:KW];
  assign pulled[2] = it5.tg.z + prod[2][KW+CW-1:KW];

  always_comb begin
    unique case (it5.kind)
      ssec_pkg::CASE_PULL: begin
        res.x = pulled[0];
        res.y = pulled[1];
        res.z = pulled[2];
      end
      ssec_pkg::CASE_INSIDE: begin
        res = it5.pick_tg ? it5.tg : it5.ey;
      end
      default: begin
        res = it5.ey;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {res.z, res.y, res.x};
      m_axis_tuser <= it5.kind;
    end
  end

`ifndef ASSERT_OFF
  a_inside_case: assert property (@(posedge clk) disable iff (rst)
    v4 && it4.kind == ssec_pkg::CASE_INSIDE |-> f0_4[PW-1])
    else $error("inside case chosen with the target outside the radius");

  a_pull_nonzero: assert property (@(posedge clk) disable iff (rst)
    v4 && it4.kind == ssec_pkg::CASE_PULL |-> dd4 != '0 && !f0_4[PW-1])
    else $error("pull case chosen for a zero segment or inside target");

  // A result that is not taken stays on the bus unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output changed while a result was waiting");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/ssec_mul.sv =====
// Two-stage signed MW x MW multiplier built from four half-width partial products.
// Depends on ssec_pkg for the operand and product widths.
`default_nettype none

module ssec_mul (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic signed [ssec_pkg::MW-1:0] a,
  input  wire logic signed [ssec_pkg::MW-1:0] b,
  output logic signed [ssec_pkg::PW-1:0]      p
);

  localparam int LW = ssec_pkg::MW / 2;
  localparam int PW = ssec_pkg::PW;

  logic signed [LW-1:0]   ah, bh;
  logic        [LW-1:0]   al, bl;
  logic signed [2*LW-1:0] hh;
  logic signed [2*LW:0]   hl, lh;
  logic        [2*LW-1:0] ll;

  assign ah = a[2*LW-1:LW];
  assign bh = b[2*LW-1:LW];
  assign al = a[LW-1:0];
  assign bl = b[LW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      hh <= ah * bh;
      hl <= ah * $signed({1'b0, bl});
      lh <= bh * $signed({1'b0, al});
      ll <= al * bl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= (PW'(hh) <<< (2 * LW)) + (PW'(hl) <<< LW) + (PW'(lh) <<< LW)
           + PW'($signed({1'b0, ll}));
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ssec_root.sv =====
// Pipelined bit-by-bit search for the crossing parameter k, one bit per stage.
// Tracks f(k)*2^64 and |d|^2*k so each stage needs only shifted adds; uses ssec_pkg.
`default_nettype none

module ssec_root (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic signed [ssec_pkg::PW-1:0] in_dd,
  input  wire logic signed [ssec_pkg::PW-1:0] in_ad,
  input  wire logic signed [ssec_pkg::PW-1:0] in_f0,
  input  wire ssec_pkg::item_t                in_item,
  output logic                                out_valid,
  output logic [ssec_pkg::KW-1:0]             out_k,
  output ssec_pkg::item_t                     out_item
);

  localparam int KW = ssec_pkg::KW;
  localparam int PW = ssec_pkg::PW;
  localparam int SW = ssec_pkg::SW;
  localparam int UW = ssec_pkg::UW;

  logic                  v_q    [KW];
  logic signed [SW-1:0]  s_q    [KW];
  logic        [UW-1:0]  u_q    [KW];
  logic        [KW-1:0]  k_q    [KW];
  logic signed [PW-1:0]  dd_q   [KW];
  logic signed [PW-1:0]  ad_q   [KW];
  ssec_pkg::item_t       item_q [KW];

  for (genvar i = 0; i < KW; i++) begin : g_stage
    localparam int B = KW - 1 - i;

    logic                 v_p;
    logic signed [SW-1:0] s_p;
    logic        [UW-1:0] u_p;
    logic        [KW-1:0] k_p;
    logic signed [PW-1:0] dd_p;
    logic signed [PW-1:0] ad_p;
    ssec_pkg::item_t      item_p;
    logic signed [SW-1:0] trial;
    logic                 take;

    if (i == 0) begin : g_first
      assign v_p    = in_valid;
      assign s_p    = {{(SW-PW-64){in_f0[PW-1]}}, in_f0, 64'b0};
      assign u_p    = '0;
      assign k_p    = '0;
      assign dd_p   = in_dd;
      assign ad_p   = in_ad;
      assign item_p = in_item;
    end else begin : g_next
      assign v_p    = v_q[i-1];
      assign s_p    = s_q[i-1];
      assign u_p    = u_q[i-1];
      assign k_p    = k_q[i-1];
      assign dd_p   = dd_q[i-1];
      assign ad_p   = ad_q[i-1];
      assign item_p = item_q[i-1];
    end

    // f(k + 2^B) = f(k) + dd*k*2^(B+1) + dd*2^(2B) + ad*2^(33+B), all scaled by 2^64.
    assign trial = s_p
                 + ({{(SW-UW){1'b0}}, u_p} << (B + 1))
                 + ({{(SW-PW){dd_p[PW-1]}}, dd_p} << (2 * B))
                 + ({{(SW-PW){ad_p[PW-1]}}, ad_p} << (33 + B));
    assign take  = !trial[SW-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_q[i]    <= take ? trial : s_p;
        u_q[i]    <= take ? u_p + ({{(UW-PW){1'b0}}, dd_p} << B) : u_p;
        k_q[i]    <= take ? (k_p | (KW'(1) << B)) : k_p;
        dd_q[i]   <= dd_p;
        ad_q[i]   <= ad_p;
        item_q[i] <= item_p;
      end
    end
  end

  assign out_valid = v_q[KW-1];
  assign out_k     = k_q[KW-1];
  assign out_item  = item_q[KW-1];

`ifndef ASSERT_OFF
  // A pulled item starts on or outside the sphere, so the kept value never goes negative.
  a_final_nonneg: assert property (@(posedge clk) disable iff (rst)
    v_q[KW-1] && item_q[KW-1].kind == ssec_pkg::CASE_PULL |-> !s_q[KW-1][SW-1])
    else $error("search ended on a negative quadratic value");

  a_entry_ok: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_item.kind == ssec_pkg::CASE_PULL |-> !in_f0[PW-1] && in_dd != '0)
    else $error("pulled item entered search with target inside or zero segment");
`endif

endmodule

`default_nettype wire

// ===== tb/ssec_checker.sv =====
// Checker for the eye clamp: watches the configuration port and both streams, predicts each
// result with exact wide arithmetic and compares in order. Depends on ssec_pkg.
`timescale 1ns / 1ps

module ssec_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [38:0]  cfg_wdata,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [239:0] s_axis_tdata,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [119:0] m_axis_tdata,
  input  wire logic [1:0]   m_axis_tuser,
  output int                errors,
  output int                pending
);

  typedef logic signed [255:0] big_t;

  typedef struct {
    logic [39:0] x;
    logic [39:0] y;
    logic [39:0] z;
    logic [1:0]  kind;
  } clamped_t;

  clamped_t                expected_eyes[$];
  logic [ssec_pkg::RW-1:0] radius;

  // Exact clamp of one target/eye pair against the clearance sphere.
  function automatic clamped_t clamp_eye(input logic [239:0] data,
                                         input logic [ssec_pkg::RW-1:0] r);
    big_t     tg[3], ey[3], d[3];
    big_t     dd, m2, f0, f1, ad, acc, kk, rb;
    logic [32:0] lo, hi, mid;
    clamped_t res;
    lo = 0;
    hi = 33'h1_0000_0000;
    for (int i = 0; i < 3; i++) begin
      tg[i] = $signed(data[40*i +: 40]);
      ey[i] = $signed(data[40*(i+3) +: 40]);
      d[i]  = ey[i] - tg[i];
    end
    res.x = ey[0][39:0];
    res.y = ey[1][39:0];
    res.z = ey[2][39:0];
    res.kind = ssec_pkg::CASE_KEEP;
    dd = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
    if (dd == 0) return res;
    rb = r;
    m2 = rb * rb;
    f0 = tg[0]*tg[0] + tg[1]*tg[1] + tg[2]*tg[2] - m2;
    f1 = ey[0]*ey[0] + ey[1]*ey[1] + ey[2]*ey[2] - m2;
    if (!f1[255]) return res;
    if (f0[255]) begin
      // Both ends inside: keep the farther one, the target on a tie.
      acc = f0 - f1;
      if (!acc[255]) begin
        res.x = tg[0][39:0];
        res.y = tg[1][39:0];
        res.z = tg[2][39:0];
      end
      res.kind = ssec_pkg::CASE_INSIDE;
      return res;
    end
    ad = tg[0]*d[0] + tg[1]*d[1] + tg[2]*d[2];
    while (hi - lo > 1) begin
      mid = lo + ((hi - lo) >> 1);
      kk  = mid;
      acc = dd*kk*kk + ((ad*kk) <<< 33) + (f0 <<< 64);
      if (!acc[255]) lo = mid;
      else hi = mid;
    end
    kk = lo;
    for (int i = 0; i < 3; i++) begin
      acc = ((d[i] * kk) >>> 32) + tg[i];
      if (i == 0) res.x = acc[39:0];
      else if (i == 1) res.y = acc[39:0];
      else res.z = acc[39:0];
    end
    res.kind = ssec_pkg::CASE_PULL;
    return res;
  endfunction

  assign pending = expected_eyes.size();

  always @(posedge clk) begin
    clamped_t want;
    int       bad;
    bad = 0;
    if (rst) begin
      radius <= '0;
      expected_eyes.delete();
      errors <= 0;
    end else begin
      if (cfg_we) radius <= cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        expected_eyes.push_back(clamp_eye(s_axis_tdata, radius));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_eyes.size() == 0) begin
          $error("result with no transaction outstanding: tdata %h", m_axis_tdata);
          bad++;
        end else begin
          want = expected_eyes.pop_front();
          if (m_axis_tdata[39:0] !== want.x) begin
            $error("out_x expected %h actual %h", want.x, m_axis_tdata[39:0]);
            bad++;
          end
          if (m_axis_tdata[79:40] !== want.y) begin
            $error("out_y expected %h actual %h", want.y, m_axis_tdata[79:40]);
            bad++;
          end
          if (m_axis_tdata[119:80] !== want.z) begin
            $error("out_z expected %h actual %h", want.z, m_axis_tdata[119:80]);
            bad++;
          end
          if (m_axis_tuser !== want.kind) begin
            $error("clamp_case expected %0d actual %0d", want.kind, m_axis_tuser);
            bad++;
          end
        end
      end
      if (bad > 0) errors <= errors + bad;
    end
  end

endmodule

// ===== tb/tb.sv =====
// Top of the eye clamp testbench: clock, reset, stimulus over several clearance radii and
// the verdict. Depends on ssec_pkg, ssec_checker and segment_sphere_eye_clamp.
`timescale 1ns / 1ps

module tb;

  localparam longint COORD_MAX = 64'sd549755813887;
  localparam longint COORD_MIN = -64'sd549755813888;
  localparam int     CYCLE_LIMIT = 600000;
  localparam int     DRAIN_CYCLES = 60;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [38:0]  cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [239:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  int           errors;
  int           pending;
  int           cycles = 0;
  int           sent = 0;
  logic [38:0]  radius = '0;

  always #5 clk = ~clk;

  segment_sphere_eye_clamp dut (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  ssec_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Uniform coordinate in [-span, span], clipped to the 40-bit range.
  function automatic logic [39:0] coord_near(input longint span);
    longint v;
    if (span < 1) span = 1;
    v = longint'({$urandom, $urandom} % (2 * span + 1)) - span;
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v[39:0];
  endfunction

  function automatic logic [39:0] coord_any();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return 40'h80_0000_0000;
      1: return 40'h7F_FFFF_FFFF;
      default: return v[39:0];
    endcase
  endfunction

  task automatic send_item(input logic [119:0] target, input logic [119:0] eye);
    s_axis_tdata  = {eye, target};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
    @(negedge clk);
    if (gap_length() > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap_length()) @(negedge clk);
    end
  endtask

  task automatic idle_and_set(input logic [38:0] value);
    s_axis_tvalid = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wdata = value;
    cfg_we    = 1'b1;
    radius    = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_items(input int count);
    longint      r;
    logic [119:0] t, e;
    r = (radius == 0) ? longint'(1) << 20 : longint'(radius);
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0: begin
          t = {coord_any(), coord_any(), coord_any()};
          e = {coord_any(), coord_any(), coord_any()};
        end
        1: begin
          t = {coord_near(2 * r), coord_near(2 * r), coord_near(2 * r)};
          e = t;
        end
        2, 3: begin
          t = {coord_near(2 * r), coord_near(2 * r), coord_near(2 * r)};
          e = {coord_near(2 * r), coord_near(2 * r), coord_near(2 * r)};
        end
        4: begin
          t = {coord_near(r / 2), coord_near(r / 2), coord_near(r / 2)};
          e = {coord_near(r / 2), coord_near(r / 2), coord_near(r / 2)};
        end
        default: begin
          // Eye inside, target within 1.5 radii on each axis and often outside: the pull toward the target.
          t = {coord_near(r + r / 2), coord_near(r + r / 2), coord_near(r + r / 2)};
          e = {coord_near(r / 2), coord_near(r / 2), coord_near(r / 2)};
        end
      endcase
      send_item(t, e);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off so the pipeline backs up.
  initial begin
    bit held;
    held = 1'b0;
    @(negedge clk);
    forever begin
      if (!held && sent > 120) begin
        held = 1;
        m_axis_tready = 1'b0;
        repeat (300) @(negedge clk);
      end
      m_axis_tready = (gap_length() == 0);
      @(negedge clk);
    end
  end

  initial begin
    logic [39:0] r10, h;
    r10 = 40'd10 << 16;
    h   = 40'd5 << 16;
    repeat (11) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Zero radius: everything passes unchanged.
    send_item({40'h80_0000_0000, 40'h7F_FFFF_FFFF, 40'd0}, {40'd0, 40'd1, 40'hFF_FFFF_FFFF});
    random_items(40);

    idle_and_set(r10[38:0]);
    send_item({40'd0, 40'd0, 40'd0}, {40'd0, 40'd0, 40'd0});              // eye equals target
    send_item({40'd0, 40'd0, r10 * 2}, {40'd0, 40'd0, r10 * 3});          // eye outside
    send_item({40'd0, 40'd0, r10}, {40'd0, 40'd0, r10});                  // on the sphere
    send_item({40'd0, 40'd0, h}, {40'd0, 40'd0, -h});                     // inside, equal distance
    send_item({40'd0, 40'd0, 40'd1}, {40'd0, 40'd0, h});                  // inside, eye farther
    send_item({40'd0, 40'd0, h}, {40'd0, 40'd0, 40'd1});                  // inside, target farther
    send_item({40'd0, 40'd0, r10 * 2}, {40'd0, 40'd0, 40'd0});            // pull, axial
    send_item({40'd0, r10 * 3, -(r10 * 2)}, {40'd7, -40'd3, 40'd1});      // pull, oblique
    send_item({40'h7F_FFFF_FFFF, 40'h7F_FFFF_FFFF, 40'h7F_FFFF_FFFF},
              {40'd0, 40'd0, 40'd0});                                      // pull from far corner
    send_item({40'h80_0000_0000, 40'h80_0000_0000, 40'h80_0000_0000},
              {40'd1, 40'd0, -40'd1});
    send_item({40'd0, 40'd0, r10}, {40'd0, 40'd0, r10 - 1});              // pull, barely inside
    random_items(150);

    idle_and_set(39'd1);
    send_item({40'd0, 40'd0, 40'd5}, {40'd0, 40'd0, 40'd0});
    random_items(60);

    idle_and_set({39{1'b1}});
    send_item({40'h80_0000_0000, 40'h80_0000_0000, 40'h80_0000_0000},
              {40'h7F_FFFF_FFFF, 40'h7F_FFFF_FFFF, 40'h7F_FFFF_FFFF});
    send_item({40'h80_0000_0000, 40'd0, 40'd0}, {40'd0, 40'd0, 40'd0});
    send_item({40'd0, 40'd0, 40'd0}, {40'h7F_FFFF_FFFF, 40'd0, 40'd0});
    random_items(150);

    idle_and_set(39'({$urandom_range(1, 255), $urandom} >> 1));
    random_items(120);

    idle_and_set(39'd1 << 30);
    random_items(110);

    s_axis_tvalid = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
